FILE: rtl/teq_pkg.sv
// Shared types and constants for the timed event queue.
package teq_pkg;

	// Request kinds
	localparam logic [2:0] KIND_INSERT    = 3'd0;
	localparam logic [2:0] KIND_RM_HANDLER = 3'd1;
	localparam logic [2:0] KIND_RM_CLIENT = 3'd2;
	localparam logic [2:0] KIND_EXPIRE    = 3'd3;
	localparam logic [2:0] KIND_CLEAR     = 3'd4;

	// Most events fired by one expire request
	localparam int MAX_FIRE = 16;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] event_time;
		logic [7:0]  handler_id;
		logic [15:0] client_tag;
	} req_t;

	typedef struct packed {
		logic        fired;
		logic [31:0] fired_time;
		logic [7:0]  fired_handler;
		logic [15:0] fired_client;
		logic        status;
		logic [4:0]  removed_count;
		logic [4:0]  queue_count;
		logic [31:0] head_time;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] due_time;
		logic [7:0]  handler;
		logic [15:0] client;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_CHK,
		ST_RM_RD,
		ST_RM_CHK,
		ST_EX_RD,
		ST_EX_CHK,
		ST_EX_END,
		ST_HEAD_RD,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		RES_PLAIN,
		RES_FIRE_NEXT,
		RES_FIRE_END
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     set_full;
		logic     clear;
		logic     ins_rd;
		logic     ins_shift;
		logic     ins_put;
		logic     rd_issue;
		logic     rm_step;
		logic     rm_done;
		logic     ex_step;
		logic     ex_done;
		logic     head_rd;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       full;
		logic       idx_zero;
		logic       later;
		logic       rd_end;
		logic       pend;
		logic       fired_any;
	} sts_t;

endpackage

FILE: rtl/teq_ctrl.sv
// Sequencing state machine for the timed event queue.
module teq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic          out_free,
	input  teq_pkg::sts_t sts,
	output teq_pkg::cmd_t cmd,
	output logic          emit
);
	import teq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		emit      = 1'b0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.kind) inside
					KIND_INSERT: begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
							state_d      = ST_HEAD_RD;
						end else begin
							state_d = ST_INS_RD;
						end
					end
					KIND_RM_HANDLER, KIND_RM_CLIENT: state_d = ST_RM_RD;
					KIND_EXPIRE: state_d = ST_EX_RD;
					KIND_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = ST_HEAD_RD;
					end
					default: state_d = ST_HEAD_RD;
				endcase
			end
			ST_INS_RD: begin
				if (sts.idx_zero) begin
					cmd.ins_put = 1'b1;
					state_d     = ST_HEAD_RD;
				end else begin
					cmd.ins_rd = 1'b1;
					state_d    = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				if (sts.later) begin
					cmd.ins_shift = 1'b1;
					state_d       = ST_INS_RD;
				end else begin
					cmd.ins_put = 1'b1;
					state_d     = ST_HEAD_RD;
				end
			end
			ST_RM_RD: begin
				if (sts.rd_end) begin
					cmd.rm_done = 1'b1;
					state_d     = ST_HEAD_RD;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_RM_CHK;
				end
			end
			ST_RM_CHK: begin
				cmd.rm_step = 1'b1;
				state_d     = ST_RM_RD;
			end
			ST_EX_RD: begin
				if (sts.rd_end) begin
					state_d = ST_EX_END;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_EX_CHK;
				end
			end
			ST_EX_CHK: begin
				// hold while a pending fired event cannot be reported
				if (!sts.pend || out_free) begin
					emit        = sts.pend;
					cmd.res_sel = RES_FIRE_NEXT;
					cmd.ex_step = 1'b1;
					state_d     = ST_EX_RD;
				end
			end
			ST_EX_END: begin
				if (sts.pend) begin
					if (out_free) begin
						emit        = 1'b1;
						cmd.res_sel = RES_FIRE_END;
						cmd.ex_done = 1'b1;
						state_d     = ST_IDLE;
					end
				end else if (sts.fired_any) begin
					cmd.ex_done = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.ex_done = 1'b1;
					state_d     = ST_HEAD_RD;
				end
			end
			ST_HEAD_RD: begin
				cmd.head_rd = 1'b1;
				state_d     = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					emit        = 1'b1;
					cmd.res_sel = RES_PLAIN;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/teq_dp.sv
// Entry memory, pointers and result formatting for the timed event queue.
module teq_dp #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  teq_pkg::req_t req_data,
	input  teq_pkg::cmd_t cmd,
	output teq_pkg::sts_t sts,
	output teq_pkg::rsp_t res
);
	import teq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	entry_t          rdata_q;
	entry_t          pend_q;
	req_t            req_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   rd_q;
	logic [CW-1:0]   wr_q;
	logic [CW-1:0]   f_q;
	logic [CW-1:0]   removed_q;
	logic [AW-1:0]   idx_q;
	logic            status_q;
	logic            firing_q;
	logic            pend_vld_q;

	logic            hit;
	logic            due;
	logic            rd_en;
	logic            wr_en;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	entry_t          new_entry;
	logic [CW-1:0]   left;

	assign new_entry = '{due_time: req_q.event_time, handler: req_q.handler_id,
		client: req_q.client_tag};

	assign hit = (req_q.kind == KIND_RM_CLIENT) ? (rdata_q.client == req_q.client_tag)
		: (rdata_q.handler == req_q.handler_id);

	// still firing, under the per-request limit, and the entry is due
	assign due = firing_q && (32'(f_q) < MAX_FIRE)
		&& (rdata_q.due_time <= req_q.event_time);

	assign rd_en   = cmd.ins_rd | cmd.rd_issue | cmd.head_rd;
	assign rd_addr = cmd.ins_rd ? (idx_q - AW'(1)) : (cmd.head_rd ? '0 : rd_q[AW-1:0]);

	assign wr_en   = cmd.ins_shift | cmd.ins_put | (cmd.rm_step & ~hit)
		| (cmd.ex_step & ~due);
	assign wr_addr = (cmd.ins_shift | cmd.ins_put) ? idx_q : wr_q[AW-1:0];
	assign wr_data = cmd.ins_put ? new_entry : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (cmd.ins_put) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.rm_done || cmd.ex_done) begin
				count_q <= wr_q;
			end
			if (cmd.clear) begin
				count_q <= '0;
			end
			if (cmd.ex_step) begin
				pend_vld_q <= due;
			end
			if (cmd.ex_done || cmd.load) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_data;
			n_q       <= count_q;
			idx_q     <= count_q[AW-1:0];
			rd_q      <= '0;
			wr_q      <= '0;
			f_q       <= '0;
			removed_q <= '0;
			status_q  <= 1'b0;
			firing_q  <= 1'b1;
		end
		if (cmd.set_full) begin
			status_q <= 1'b1;
		end
		if (cmd.clear) begin
			removed_q <= count_q;
		end
		if (cmd.ins_shift) begin
			idx_q <= idx_q - AW'(1);
		end
		if (cmd.rm_step) begin
			rd_q <= rd_q + CW'(1);
			if (!hit) begin
				wr_q <= wr_q + CW'(1);
			end
		end
		if (cmd.rm_done) begin
			removed_q <= n_q - wr_q;
		end
		if (cmd.ex_step) begin
			rd_q <= rd_q + CW'(1);
			if (due) begin
				pend_q <= rdata_q;
				f_q    <= f_q + CW'(1);
			end else begin
				firing_q <= 1'b0;
				wr_q     <= wr_q + CW'(1);
			end
		end
	end

	assign sts.kind      = req_q.kind;
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.idx_zero  = (idx_q == '0);
	assign sts.later     = (rdata_q.due_time > req_q.event_time);
	assign sts.rd_end    = (rd_q == n_q);
	assign sts.pend      = pend_vld_q;
	assign sts.fired_any = (f_q != '0);

	assign left = n_q - f_q;

	always_comb begin
		res = '0;
		unique case (cmd.res_sel)
			RES_FIRE_NEXT: begin
				res.fired         = 1'b1;
				res.fired_time    = pend_q.due_time;
				res.fired_handler = pend_q.handler;
				res.fired_client  = pend_q.client;
				res.queue_count   = 5'(left);
				res.head_time     = rdata_q.due_time;
				res.last          = ~due;
			end
			RES_FIRE_END: begin
				res.fired         = 1'b1;
				res.fired_time    = pend_q.due_time;
				res.fired_handler = pend_q.handler;
				res.fired_client  = pend_q.client;
				res.queue_count   = 5'(left);
				res.last          = 1'b1;
			end
			default: begin
				res.status        = status_q;
				res.removed_count = 5'(removed_q);
				res.queue_count   = 5'(count_q);
				res.head_time     = (count_q != '0) ? rdata_q.due_time : 32'd0;
				res.last          = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/timed_event_queue_top.sv
// Top level of the timed event queue: controller, datapath and result register.
//
// Keeps up to DEPTH pending events sorted by due time (stable for equal
// times) in a single-port entry memory with a registered read. One request
// is handled at a time; req_ready is high only while the sequencer is idle.
// Each entry touched takes a read state, then a state that acts on the read
// data. An insert walks down from the tail, shifting up each entry due
// later; a remove and an expire walk every entry; a clear, a spare kind or
// an insert into a full queue only read the head. The result side can
// hold the block off. Every request gives one result; an expire that finds
// due events gives one result per fired event (at most 16, earliest first)
// with last set on the final one. A finished result waits in the output
// register while the block goes on with the rest of the request.
module timed_event_queue_top #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  teq_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output teq_pkg::rsp_t rsp_data
);
	import teq_pkg::*;

	cmd_t cmd;
	sts_t sts;
	rsp_t res;
	logic emit;
	logic out_free;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// The output register can take a new result when empty or being drained.
	assign out_free = ~rsp_valid_q | rsp_ready;

	teq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.out_free  (out_free),
		.sts       (sts),
		.cmd       (cmd),
		.emit      (emit)
	);

	teq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (cmd),
		.sts      (sts),
		.res      (res)
	);

	// Hold the result until taken; load a new one when the controller emits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Never overwrite a result that is still waiting.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result emitted into a full output register");

	// One request at a time: acceptance drops ready for the next cycle.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// Fired events leave in time order: the next head is not earlier.
	a_fire_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.fired && !res.last |-> res.head_time >= res.fired_time)
		else $error("fired event is later than the remaining head");

	// A request is taken only when no fired event is still pending.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !sts.pend)
		else $error("sequencer idle with a fired event unreported");

endmodule

FILE: sim/timed_event_queue_top_tb.sv
// Self-checking testbench for timed_event_queue_top against a shadow queue.
module timed_event_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import teq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 80;
	// Cycles with no handshake on either side before the run is declared hung.
	// The slowest request walks a full queue; with a long gap on each side this
	// is still many times the worst correct stretch.
	localparam int QUIET_LIMIT  = 2000;
	// Settle time after the last expected result: covers a full-depth walk.
	localparam int END_SETTLE   = 100;

	typedef struct {
		req_t req;
		int   gap;
	} req_slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	// Stimulus backlog, filled once by the initial block and drained by the driver.
	req_slot_t req_backlog[$];
	int        req_total;
	int        directed_total;

	// Shadow copy of the event queue and the results it predicts.
	entry_t shadow_slot[DEPTH];
	int     shadow_count = 0;
	rsp_t   awaited_rsp[$];

	// Running tallies for checking and the end-of-run summary.
	int req_seen    = 0;
	int rsp_seen    = 0;
	int fired_seen  = 0;
	int drops_seen  = 0;
	int burst_run   = 0;
	int burst_max   = 0;
	int fault_count = 0;

	// Drifting notion of "now" so random inserts and expires land close together.
	logic [31:0] tick_now;

	int          req_wait;
	int          rsp_stall;
	int unsigned cycle_no;

	timed_event_queue_top #(.DEPTH(DEPTH)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Favor a small pool so removes find matches; the pool holds both extremes.
	function automatic logic [7:0] pick_handler();
		logic [7:0] pool[4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
		if ($urandom_range(0, 99) < 70)
			return pool[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_client();
		logic [15:0] pool[4] = '{16'h0000, 16'h1234, 16'hBEEF, 16'hFFFF};
		if ($urandom_range(0, 99) < 70)
			return pool[$urandom_range(0, 3)];
		return 16'($urandom_range(0, 65535));
	endfunction

	// Due times cluster just after "now" (with ties), some already due,
	// some anywhere, a few at the extremes.
	function automatic logic [31:0] pick_due_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return tick_now + 32'($urandom_range(0, 40));
		if (r < 75)
			return tick_now - 32'($urandom_range(0, 20));
		if (r < 90)
			return $urandom;
		return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
	endfunction

	task automatic add_req(logic [2:0] kind, logic [31:0] t, logic [7:0] h, logic [15:0] c,
			bit calm);
		req_slot_t s;
		s.req.kind       = kind;
		s.req.event_time = t;
		s.req.handler_id = h;
		s.req.client_tag = c;
		s.gap            = pick_gap(calm);
		req_backlog.push_back(s);
	endtask

	// ------------------------------------------------------------------
	// Shadow queue
	// ------------------------------------------------------------------

	// Build one result from the shadow state as it stands now.
	function automatic rsp_t result_now(logic fired, entry_t e, logic status, int removed,
			logic last);
		rsp_t o;
		o = '0;
		o.fired = fired;
		if (fired) begin
			o.fired_time    = e.due_time;
			o.fired_handler = e.handler;
			o.fired_client  = e.client;
		end
		o.status        = status;
		o.removed_count = 5'(removed);
		o.queue_count   = 5'(shadow_count);
		o.head_time     = (shadow_count > 0) ? shadow_slot[0].due_time : 32'h0;
		o.last          = last;
		return o;
	endfunction

	// Apply one accepted request to the shadow queue and queue up its results.
	task automatic track_queue_op(req_t r);
		int     pos;
		int     wr;
		int     fired;
		int     removed;
		logic   status;
		bit     have_held;
		bit     keep;
		rsp_t   held;
		entry_t head;
		status    = 1'b0;
		removed   = 0;
		fired     = 0;
		have_held = 1'b0;
		case (r.kind) inside
			KIND_INSERT: begin
				// Full queue: drop the insert and flag it.
				if (shadow_count >= DEPTH) begin
					status = 1'b1;
				end else begin
					// Stable insert: skip past every entry due at or before the new time.
					pos = 0;
					while (pos < shadow_count && shadow_slot[pos].due_time <= r.event_time)
						pos++;
					for (int i = shadow_count; i > pos; i--)
						shadow_slot[i] = shadow_slot[i - 1];
					shadow_slot[pos].due_time = r.event_time;
					shadow_slot[pos].handler  = r.handler_id;
					shadow_slot[pos].client   = r.client_tag;
					shadow_count++;
				end
			end
			KIND_RM_HANDLER, KIND_RM_CLIENT: begin
				// Compact the survivors toward the head, keeping their order.
				wr = 0;
				for (int rd = 0; rd < shadow_count; rd++) begin
					if (r.kind == KIND_RM_HANDLER)
						keep = (shadow_slot[rd].handler != r.handler_id);
					else
						keep = (shadow_slot[rd].client != r.client_tag);
					if (keep) begin
						shadow_slot[wr] = shadow_slot[rd];
						wr++;
					end
				end
				removed      = shadow_count - wr;
				shadow_count = wr;
			end
			KIND_EXPIRE: begin
				// Pop due events earliest first; hold the newest so the final one gets last.
				while (fired < MAX_FIRE && shadow_count > 0
						&& shadow_slot[0].due_time <= r.event_time) begin
					head = shadow_slot[0];
					for (int i = 1; i < shadow_count; i++)
						shadow_slot[i - 1] = shadow_slot[i];
					shadow_count--;
					if (have_held)
						awaited_rsp.push_back(held);
					held      = result_now(1'b1, head, 1'b0, 0, 1'b0);
					have_held = 1'b1;
					fired++;
				end
			end
			KIND_CLEAR: begin
				removed      = shadow_count;
				shadow_count = 0;
			end
			default: begin
				// Spare kinds leave the queue alone and give one plain result.
			end
		endcase
		if (have_held) begin
			held.last = 1'b1;
			awaited_rsp.push_back(held);
		end else begin
			// Covers the nothing-due expire as well as every other kind.
			awaited_rsp.push_back(result_now(1'b0, '0, status, removed, 1'b1));
		end
	endtask

	function automatic string format_rsp(rsp_t r);
		return $sformatf({"{fired %0d time %h hnd %h cli %h status %0d removed %0d ",
			"count %0d head %h last %0d}"}, r.fired, r.fired_time, r.fired_handler,
			r.fired_client, r.status, r.removed_count, r.queue_count, r.head_time, r.last);
	endfunction

	// Report the first ten faults in full; just count the rest.
	task automatic log_fault(string msg);
		if (fault_count < 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		fault_count++;
	endtask

	// ------------------------------------------------------------------
	// Request driver: present backlog items, hold each until accepted,
	// then idle for the item's gap before the next one.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : req_driver
		req_slot_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
			req_wait  <= 0;
		end else if (!req_valid || req_ready) begin
			if (req_wait != 0) begin
				req_valid <= 1'b0;
				req_wait  <= req_wait - 1;
			end else if (req_backlog.size() != 0) begin
				nxt = req_backlog.pop_front();
				req_valid <= 1'b1;
				req_data  <= nxt.req;
				req_wait  <= nxt.gap;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: stall after a result at random. One window in four (cycle
	// count bits 9:8 zero) runs with no stalls so back-to-back bursts get exercised.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : rsp_throttle
		int g;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_stall <= 0;
			cycle_no  <= 0;
		end else begin
			cycle_no <= cycle_no + 1;
			if (rsp_stall != 0) begin
				rsp_ready <= 1'b0;
				rsp_stall <= rsp_stall - 1;
			end else if (rsp_valid && rsp_ready) begin
				g = pick_gap(cycle_no[9:8] == 2'b00);
				rsp_ready <= (g == 0);
				rsp_stall <= (g == 0) ? 0 : g - 1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check the accepted result against the oldest expectation
	// first, then fold any accepted request into the shadow queue, so the
	// order within an edge is fixed.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		rsp_t  want;
		string diffs;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (rsp_data.fired === 1'b1) begin
					fired_seen++;
					burst_run++;
					if (burst_run > burst_max)
						burst_max = burst_run;
				end
				if (rsp_data.last === 1'b1)
					burst_run = 0;
				if (rsp_data.status === 1'b1)
					drops_seen++;
				if (awaited_rsp.size() == 0) begin
					log_fault($sformatf("result %0d with none expected: %s", rsp_seen,
						format_rsp(rsp_data)));
				end else begin
					want  = awaited_rsp.pop_front();
					diffs = "";
					if (rsp_data.fired !== want.fired)
						diffs = {diffs, " fired"};
					if (rsp_data.fired_time !== want.fired_time)
						diffs = {diffs, " fired_time"};
					if (rsp_data.fired_handler !== want.fired_handler)
						diffs = {diffs, " fired_handler"};
					if (rsp_data.fired_client !== want.fired_client)
						diffs = {diffs, " fired_client"};
					if (rsp_data.status !== want.status)
						diffs = {diffs, " status"};
					if (rsp_data.removed_count !== want.removed_count)
						diffs = {diffs, " removed_count"};
					if (rsp_data.queue_count !== want.queue_count)
						diffs = {diffs, " queue_count"};
					if (rsp_data.head_time !== want.head_time)
						diffs = {diffs, " head_time"};
					if (rsp_data.last !== want.last)
						diffs = {diffs, " last"};
					if (diffs != "")
						log_fault($sformatf(
							"result %0d wrong in%s\n  expected %s\n  actual   %s",
							rsp_seen, diffs, format_rsp(want), format_rsp(rsp_data)));
				end
			end
			if (req_valid && req_ready) begin
				track_queue_op(req_data);
				req_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if nothing moves on either side for too long.
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no handshake for %0d cycles, %0d results still awaited", $realtime,
			QUIET_LIMIT, awaited_rsp.size());
		$display("timed_event_queue_top verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: build the stimulus, release reset, wait for the drain.
	// ------------------------------------------------------------------
	initial begin : main_seq
		int  n_random;
		int  seg;
		int  r;
		bit  calm;
		tick_now = 32'($urandom_range(0, 32'h7FFF_FFFF));

		// Directed part.
		// Expire on an empty queue: nothing due.
		add_req(KIND_EXPIRE, 32'hFFFF_FFFF, 8'h00, 16'h0000, 1'b0);
		// Extremes of every field, two equal times to check stable ordering.
		add_req(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b0);
		add_req(KIND_INSERT, 32'd100, 8'h00, 16'h0000, 1'b0);
		add_req(KIND_INSERT, 32'd100, 8'h01, 16'hBEEF, 1'b0);
		add_req(KIND_INSERT, 32'd50, 8'h5A, 16'h0002, 1'b0);
		// Expire before the earliest due time: nothing due in a non-empty queue.
		add_req(KIND_EXPIRE, 32'd49, 8'hFF, 16'hFFFF, 1'b0);
		// Fill to DEPTH with ties at 0 and 100 and repeated keys for the removes.
		for (int i = 0; i < 12; i++)
			add_req(KIND_INSERT,
				(i < 2) ? 32'd0 : ((i % 3 == 0) ? 32'd100 : 32'(40 + 7 * i)),
				(i % 3 == 0) ? 8'h5A : 8'(i),
				(i % 4 == 1) ? 16'hBEEF : 16'(16'h0100 + i), 1'b0);
		// Queue full: drop this one.
		add_req(KIND_INSERT, 32'd1, 8'h77, 16'h7777, 1'b0);
		add_req(KIND_RM_HANDLER, 32'hA5A5_A5A5, 8'h5A, 16'h0001, 1'b0);
		add_req(KIND_RM_CLIENT, 32'h5A5A_5A5A, 8'h02, 16'hBEEF, 1'b0);
		// Many due at once.
		add_req(KIND_EXPIRE, 32'd100, 8'h00, 16'h0000, 1'b0);
		// Spare kinds past clear change nothing.
		add_req(KIND_CLEAR + 3'd1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b0);
		add_req(KIND_CLEAR + 3'd3, 32'h0000_0000, 8'h00, 16'h0000, 1'b0);
		add_req(KIND_CLEAR, 32'h1234_5678, 8'h12, 16'h3456, 1'b0);
		directed_total = req_backlog.size();

		// Random part: mixed segments, plus fill bursts that top up the queue
		// (often overflowing it) and then one expire at the top time or just after now.
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				seg = $urandom_range(14, 18);
				for (int k = 0; k < seg; k++)
					add_req(KIND_INSERT, pick_due_time(), pick_handler(), pick_client(), calm);
				add_req(KIND_EXPIRE,
					($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : tick_now + 32'd40,
					8'($urandom), 16'($urandom), calm);
				n_random += seg + 1;
			end else begin
				seg = $urandom_range(6, 14);
				for (int k = 0; k < seg; k++) begin
					r = $urandom_range(0, 99);
					if (r < 48) begin
						add_req(KIND_INSERT, pick_due_time(), pick_handler(), pick_client(),
							calm);
					end else if (r < 60) begin
						add_req(KIND_RM_HANDLER, $urandom, pick_handler(), 16'($urandom), calm);
					end else if (r < 70) begin
						add_req(KIND_RM_CLIENT, $urandom, 8'($urandom), pick_client(), calm);
					end else if (r < 90) begin
						// Advance "now" on most expires so due events keep coming.
						if ($urandom_range(0, 99) < 80) begin
							tick_now = tick_now + 32'($urandom_range(0, 30));
							add_req(KIND_EXPIRE, tick_now, 8'($urandom), 16'($urandom), calm);
						end else begin
							add_req(KIND_EXPIRE, $urandom, 8'($urandom), 16'($urandom), calm);
						end
					end else if (r < 94) begin
						add_req(KIND_CLEAR, $urandom, 8'($urandom), 16'($urandom), calm);
					end else begin
						add_req(KIND_CLEAR + 3'($urandom_range(1, 3)), $urandom, 8'($urandom),
							16'($urandom), calm);
					end
				end
				n_random += seg;
			end
		end
		req_total = req_backlog.size();

		// Hold reset, then release it on a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every result to come back,
		// then give the block time to show any stray result.
		while (req_seen < req_total)
			@(posedge clk);
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);

		if (awaited_rsp.size() != 0)
			log_fault($sformatf("%0d results never arrived", awaited_rsp.size()));

		$display("Summary: %0d requests (%0d directed), %0d results, %0d events fired",
			req_seen, directed_total, rsp_seen, fired_seen);
		$display("Summary: %0d inserts dropped on a full queue, longest fire burst %0d,",
			drops_seen, burst_max);
		$display("Summary: %0d faults", fault_count);
		if (fault_count == 0)
			$display("timed_event_queue_top verification clean");
		else
			$display("timed_event_queue_top verification failed");
		$finish;
	end

endmodule
